>>> rtl/css_pkg.sv
// Shared types and constants for the cocktail shaker sorter.
package css_pkg;

  // Element width is fixed by the payload structs.
  localparam int DATA_WIDTH = 32;
  localparam int COMP_WIDTH = 12;
  localparam logic [COMP_WIDTH-1:0] COMP_MAX = 12'd4095;

  // Cell operation codes.
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_SORT  = 2'd2;
  localparam logic [1:0] OP_SHIFT = 2'd3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [1:0] op;
    logic       odd_phase;
  } cell_ctrl_t;

  typedef struct packed {
    data_t value;
    logic  last;
  } in_item_t;

  typedef struct packed {
    data_t                 sorted_value;
    logic                  last_out;
    logic [COMP_WIDTH-1:0] comparison_count;
    logic                  overflow;
  } result_t;

endpackage

>>> rtl/css_cell.sv
// One storage cell of the sorting chain with its compare-and-swap logic.
module css_cell #(
  parameter bit ODD       = 1'b0,
  parameter bit HAS_LEFT  = 1'b1,
  parameter bit HAS_RIGHT = 1'b1
) (
  input  logic                clk,
  input  logic                rst,
  input  css_pkg::cell_ctrl_t ctrl,
  input  css_pkg::data_t      left_value,
  input  logic                left_valid,
  input  css_pkg::data_t      right_value,
  input  logic                right_valid,
  output css_pkg::data_t      value,
  output logic                valid
);
  import css_pkg::*;

  data_t value_next;
  logic  valid_next;
  logic  is_lower;
  logic  swap_lower;
  logic  swap_upper;

  // An empty cell counts as larger than any stored element.
  assign is_lower   = (ctrl.odd_phase == ODD);
  assign swap_lower = right_valid && (!valid || (right_value < value));
  assign swap_upper = valid && (!left_valid || (value < left_value));

  // Next contents for each operation.
  always_comb begin
    value_next = value;
    valid_next = valid;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        value_next = left_value;
        valid_next = left_valid;
      end
      OP_SORT: begin
        if (is_lower && HAS_RIGHT && swap_lower) begin
          value_next = right_value;
          valid_next = right_valid;
        end else if (!is_lower && HAS_LEFT && swap_upper) begin
          value_next = left_value;
          valid_next = left_valid;
        end
      end
      OP_SHIFT: begin
        value_next = right_value;
        valid_next = right_valid;
      end
      default: begin
      end
    endcase
  end

  // Contents register; only the valid bit needs reset.
  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

>>> rtl/cocktail_shaker_sorter.sv
// Top level of the cocktail shaker sorter: sequencer and chain of cells.
//
//  Channel   Handshake              Payload
//  input     start / busy           in_item  (value, last)
//  result    result_valid strobe    result   (sorted_value, last_out,
//                                             comparison_count, overflow)
//
// Each accepted start loads one element while there is room. After the element
// with the last mark, the chain runs n odd-even exchange phases and then shifts
// out n results, one per cycle.
// busy is high from the last element until the final result has gone.
// Reset empties the chain and clears the element count and the drop flag.
// The receiver cannot stall: each result is present for one cycle only.
module cocktail_shaker_sorter #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  css_pkg::in_item_t in_item,
  output logic              result_valid,
  output css_pkg::result_t  result
);
  import css_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = 2 * CW;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         phase;
  logic [CW-1:0]         phase_next;
  logic                  dropped;
  logic                  dropped_next;
  logic [COMP_WIDTH-1:0] comps;
  logic [COMP_WIDTH-1:0] comps_next;
  logic                  accept;
  logic                  has_room;
  logic                  phase_end;
  logic [PW-1:0]         pair_product;
  logic [PW+COMP_WIDTH-1:0] half_product;
  cell_ctrl_t            ctrl;

  data_t                 cell_value [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] cell_valid;

  assign busy      = (state != S_LOAD);
  assign accept    = start && !busy;
  assign has_room  = (count < CW'(MAX_ELEMENTS));
  assign phase_end = (phase == (count - CW'(1)));

  // Comparisons of a full shaker sort: n(n-1)/2, saturated.
  assign pair_product = PW'(count) * PW'(count - CW'(1));
  assign half_product = {{COMP_WIDTH{1'b0}}, pair_product} >> 1;
  assign comps_next   = (half_product > (PW+COMP_WIDTH)'(COMP_MAX)) ? COMP_MAX
                                                                   : half_product[COMP_WIDTH-1:0];

  // Sequencer: load, exchange phases, shift-out.
  always_comb begin
    state_next   = state;
    count_next   = count;
    phase_next   = phase;
    dropped_next = dropped;
    ctrl.op        = OP_HOLD;
    ctrl.odd_phase = phase[0];
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (has_room) begin
            ctrl.op    = OP_LOAD;
            count_next = count + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (in_item.last) begin
            state_next = S_SORT;
            phase_next = '0;
          end
        end
      end
      S_SORT: begin
        ctrl.op = OP_SORT;
        if (phase_end) begin
          state_next = S_OUT;
          phase_next = '0;
        end else begin
          phase_next = phase + CW'(1);
        end
      end
      S_OUT: begin
        ctrl.op = OP_SHIFT;
        if (phase_end) begin
          state_next   = S_LOAD;
          count_next   = '0;
          dropped_next = 1'b0;
          phase_next   = '0;
        end else begin
          phase_next = phase + CW'(1);
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      phase   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      phase   <= phase_next;
      dropped <= dropped_next;
    end
  end

  // Comparison total is taken while the chain sorts.
  always_ff @(posedge clk) begin
    if (state == S_SORT) begin
      comps <= comps_next;
    end
  end

  // Row of cells: loads enter at cell 0, results leave from cell 0.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    data_t left_value;
    logic  left_valid;
    data_t right_value;
    logic  right_valid;

    if (i == 0) begin : g_first
      assign left_value = in_item.value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    css_cell #(
      .ODD       ((i % 2) == 1),
      .HAS_LEFT  (i != 0),
      .HAS_RIGHT (i != MAX_ELEMENTS - 1)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i])
    );
  end

  // Result transfer, one element per cycle during shift-out.
  assign result_valid            = (state == S_OUT);
  assign result.sorted_value     = cell_value[0];
  assign result.last_out         = phase_end;
  assign result.comparison_count = comps;
  assign result.overflow         = dropped;

`ifndef NO_ASSERTIONS
  // A run's final result returns the block to loading.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_out |=> !busy)
    else $error("block still busy after final result");

  // An element with the last mark starts sorting.
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.last |=> (state == S_SORT))
    else $error("last element did not start the sort");

  // Every shifted-out result comes from an occupied cell.
  a_out_valid_cell: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cell_valid[0])
    else $error("result taken from an empty cell");

  // The element count never exceeds the chain length.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");
`endif

endmodule
